// File: hdl/assert_macros.svh
// assertion macros used by the rtl module mbs_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MBS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MBS_ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`else
`define MBS_ASSERT(label, clk, rst_n, prop)
`define MBS_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// File: hdl/mbs_pkg.sv
// shared constants, types and helper functions of the maze solver
`default_nettype none
package mbs_pkg;
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 32;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int DEPTH_W  = $clog2(CELLS + 1);

    localparam int OP_W       = 2;
    localparam int CODE_W     = 3;
    localparam int DIR_W      = 2;
    localparam int TRY_W      = 3;
    localparam int CFG_COLS_W = 7;
    localparam int CFG_ROWS_W = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd1;
    localparam logic [CFG_COLS_W-1:0] COLS_RST = 7'd50;
    localparam logic [CFG_ROWS_W-1:0] ROWS_RST = 6'd21;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [CODE_W-1:0] CODE_OPEN = 3'd0;
    localparam logic [CODE_W-1:0] CODE_GOAL = 3'd2;
    localparam logic [CODE_W-1:0] CODE_PATH = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DEAD = 3'd4;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

    // grid size in effect, already clipped to the store
    typedef struct packed {
        logic [COL_W:0] cols;
        logic [ROW_W:0] rows;
    } t_dims;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             ok;
    } t_nbr;

    function automatic logic in_grid(logic [COL_W:0] c, logic [ROW_W:0] r, t_dims d);
        return (c < d.cols) && (r < d.rows);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(logic [COL_W-1:0] c,
                                                   logic [ROW_W-1:0] r);
        return ADDR_W'(r * MAX_COLS) + ADDR_W'(c);
    endfunction
endpackage
`default_nettype wire

// File: hdl/mbs_in_if.sv
// request channel: opcode and cell fields with valid/ready
`default_nettype none
interface mbs_in_if;
    import mbs_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
    logic [CODE_W-1:0] cell_code;

    modport source (output valid, opcode, cell_col, cell_row, cell_code, input ready);
    modport sink   (input valid, opcode, cell_col, cell_row, cell_code, output ready);
endinterface
`default_nettype wire

// File: hdl/mbs_out_if.sv
// result channel: read code and found flag with valid/ready
`default_nettype none
interface mbs_out_if;
    import mbs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] read_code;
    logic              found;

    modport source (output valid, read_code, found, input ready);
    modport sink   (input valid, read_code, found, output ready);
endinterface
`default_nettype wire

// File: hdl/mbs_nbr.sv
// neighbor cell of the walk position in one direction, with grid bound check
`default_nettype none
module mbs_nbr (
    input  wire logic [mbs_pkg::COL_W-1:0] i_col,
    input  wire logic [mbs_pkg::ROW_W-1:0] i_row,
    input  wire logic [mbs_pkg::DIR_W-1:0] i_dir,
    input  wire mbs_pkg::t_dims            i_dims,
    output mbs_pkg::t_nbr                  o_nbr
);
    import mbs_pkg::*;

    logic [COL_W:0] col_x;
    logic [COL_W:0] nc;
    logic [ROW_W:0] row_x;
    logic [ROW_W:0] nr;

    // stepping off the low edge wraps to all ones, which fails the bound check
    always_comb begin
        col_x = {1'b0, i_col};
        row_x = {1'b0, i_row};
        nc    = col_x;
        nr    = row_x;
        unique case (i_dir)
            DIR_RIGHT: nc = col_x + (COL_W+1)'(1);
            DIR_DOWN:  nr = row_x + (ROW_W+1)'(1);
            DIR_LEFT:  nc = col_x - (COL_W+1)'(1);
            DIR_UP:    nr = row_x - (ROW_W+1)'(1);
        endcase
        o_nbr.col = nc[COL_W-1:0];
        o_nbr.row = nr[ROW_W-1:0];
        o_nbr.ok  = in_grid(nc, nr, i_dims);
    end
endmodule
`default_nettype wire

// File: hdl/mbs_core.sv
// walk sequencer with grid and direction stack memories and the result register
`default_nettype none
`include "assert_macros.svh"
module mbs_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mbs_pkg::t_dims i_dims,
    mbs_in_if.sink              i_item,
    mbs_out_if.source           o_result
);
    import mbs_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RD_WAIT = 3'd1;
    localparam logic [2:0] ST_TRY     = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_POP     = 3'd4;

    localparam logic [TRY_W-1:0] TRY_DONE = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [TRY_W-1:0]   r_try, n_try;
    logic               r_out_valid, n_out_valid;
    logic [CODE_W-1:0]  r_read_code, n_read_code;
    logic               r_found, n_found;

    logic [CODE_W-1:0] grid_mem [CELLS];
    logic [DIR_W-1:0]  stack_mem [CELLS];
    logic [CODE_W-1:0] r_grid_q;
    logic [DIR_W-1:0]  r_stack_q;

    logic              grid_we, grid_re, stack_we, stack_re;
    logic [ADDR_W-1:0] grid_waddr, grid_raddr;
    logic [CODE_W-1:0] grid_wdata;

    logic              in_fire, out_fire, addr_ok;
    logic              goal_hit;
    logic [ADDR_W-1:0] item_addr, walk_addr, nbr_addr;
    logic [DEPTH_W-1:0] depth_dec;
    logic [DIR_W-1:0]  nbr_dir;
    t_nbr              nbr;

    assign in_fire   = i_item.valid && i_item.ready;
    assign out_fire  = o_result.valid && o_result.ready;
    assign i_item.ready = (r_state == ST_IDLE) && (!r_out_valid || o_result.ready);

    assign o_result.valid     = r_out_valid;
    assign o_result.read_code = r_read_code;
    assign o_result.found     = r_found;

    assign addr_ok   = (int'(i_item.cell_col) < MAX_COLS) && (int'(i_item.cell_row) < MAX_ROWS);
    assign item_addr = cell_addr(i_item.cell_col, i_item.cell_row);
    assign walk_addr = cell_addr(r_col, r_row);
    assign nbr_addr  = cell_addr(nbr.col, nbr.row);
    assign depth_dec = r_depth - DEPTH_W'(1);
    assign goal_hit  = (r_state == ST_CHECK) && (r_grid_q == CODE_GOAL);

    // on a step back, move opposite to the direction that was pushed
    assign nbr_dir = (r_state == ST_POP) ? (r_stack_q ^ DIR_LEFT) : r_try[DIR_W-1:0];

    mbs_nbr u_nbr (
        .i_col  (r_col),
        .i_row  (r_row),
        .i_dir  (nbr_dir),
        .i_dims (i_dims),
        .o_nbr  (nbr)
    );

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_col       = r_col;
        n_row       = r_row;
        n_try       = r_try;
        n_out_valid = r_out_valid && !out_fire;
        n_read_code = r_read_code;
        n_found     = r_found;
        grid_we     = 1'b0;
        grid_waddr  = item_addr;
        grid_wdata  = i_item.cell_code;
        grid_re     = 1'b0;
        grid_raddr  = item_addr;
        stack_we    = 1'b0;
        stack_re    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_read_code = '0;
                    n_found     = 1'b0;
                    unique case (i_item.opcode)
                        OP_WRITE: begin
                            grid_we     = addr_ok;
                            n_out_valid = 1'b1;
                        end
                        OP_READ: begin
                            if (addr_ok) begin
                                grid_re = 1'b1;
                                n_state = ST_RD_WAIT;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            n_col   = i_item.cell_col;
                            n_row   = i_item.cell_row;
                            n_depth = '0;
                            n_try   = '0;
                            if (in_grid({1'b0, i_item.cell_col}, {1'b0, i_item.cell_row},
                                        i_dims)) begin
                                n_state = ST_TRY;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                n_read_code = r_grid_q;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_TRY: begin
                if (r_try == TRY_DONE) begin
                    if (r_depth == '0) begin
                        n_found     = 1'b0;
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        // cell exhausted: mark it and fetch the way back
                        grid_we    = 1'b1;
                        grid_waddr = walk_addr;
                        grid_wdata = CODE_DEAD;
                        n_depth    = depth_dec;
                        stack_re   = 1'b1;
                        n_state    = ST_POP;
                    end
                end else if (nbr.ok) begin
                    grid_re    = 1'b1;
                    grid_raddr = nbr_addr;
                    n_state    = ST_CHECK;
                end else begin
                    n_try = r_try + TRY_W'(1);
                end
            end
            ST_CHECK: begin
                if (goal_hit) begin
                    n_found     = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else if (r_grid_q == CODE_OPEN && r_depth < DEPTH_W'(CELLS)) begin
                    grid_we    = 1'b1;
                    grid_waddr = nbr_addr;
                    grid_wdata = CODE_PATH;
                    stack_we   = 1'b1;
                    n_depth    = r_depth + DEPTH_W'(1);
                    n_col      = nbr.col;
                    n_row      = nbr.row;
                    n_try      = '0;
                    n_state    = ST_TRY;
                end else begin
                    n_try   = r_try + TRY_W'(1);
                    n_state = ST_TRY;
                end
            end
            ST_POP: begin
                n_col   = nbr.col;
                n_row   = nbr.row;
                n_try   = TRY_W'(r_stack_q) + TRY_W'(1);
                n_state = ST_TRY;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_try       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_col       <= n_col;
            r_row       <= n_row;
            r_try       <= n_try;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_code <= n_read_code;
        r_found     <= n_found;
    end

    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        if (grid_re) begin
            r_grid_q <= grid_mem[grid_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            stack_mem[r_depth[ADDR_W-1:0]] <= r_try[DIR_W-1:0];
        end
        if (stack_re) begin
            r_stack_q <= stack_mem[depth_dec[ADDR_W-1:0]];
        end
    end

    `MBS_ASSERT(a_depth_bound, i_clk, i_rst_n, r_depth <= DEPTH_W'(CELLS))
    `MBS_ASSERT(a_goal_reports, i_clk, i_rst_n, goal_hit |=> (r_out_valid && r_found))
    `MBS_ASSERT(a_push_step, i_clk, i_rst_n, stack_we |=> r_depth == $past(r_depth) + DEPTH_W'(1))
    `MBS_ASSERT(a_result_from_idle, i_clk, i_rst_n, $rose(r_out_valid) |-> r_state == ST_IDLE)
    `MBS_ASSERT_NEVER(a_grid_port_clash, i_clk, i_rst_n, grid_we && grid_re)
endmodule
`default_nettype wire

// File: hdl/maze_backtracking_solver.sv
// maze solver top level: configuration registers and the walk core
// a write answers from the result register; a read answers after one grid memory read
// a search tries each in-grid neighbor by a grid read and a check, skips those off the
// grid, steps back by a stack memory read and reports a miss when the start cell is spent
// one item in work at a time, the next taken no earlier than the last result transfers, so
// writes run one per cycle while results are taken; reset: grid 50 x 21, memories keep contents
`default_nettype none
module maze_backtracking_solver (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    mbs_in_if.sink                                 i_item,
    mbs_out_if.source                              o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [mbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [mbs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import mbs_pkg::*;

    logic [CFG_COLS_W-1:0] r_cols;
    logic [CFG_ROWS_W-1:0] r_rows;
    t_dims                 dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RST;
            r_rows <= ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COLS: r_cols <= i_cfg_wdata[CFG_COLS_W-1:0];
                REG_ROWS: r_rows <= i_cfg_wdata[CFG_ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes beyond the store saturate to it
    always_comb begin
        dims.cols = (int'(r_cols) > MAX_COLS) ? (COL_W+1)'(MAX_COLS) : (COL_W+1)'(r_cols);
        dims.rows = (int'(r_rows) > MAX_ROWS) ? (ROW_W+1)'(MAX_ROWS) : (ROW_W+1)'(r_rows);
    end

    mbs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dims   (dims),
        .i_item   (i_item),
        .o_result (o_result)
    );
endmodule
`default_nettype wire
